// File: sv/gwwb_pkg.sv
package gwwb_pkg;
    localparam int MAX_PIXELS_DEF = 16384;
    localparam int PIX_W = 24;
    localparam int CH_W = 8;
    localparam int CFG_W = 15;
    localparam int FRAME_RESET = 16384;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EMIT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } div_ctl_t;
endpackage

// File: sv/gwwb_if.sv
interface gwwb_in_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] blue_in;
    logic [7:0] green_in;
    logic [7:0] red_in;
    modport source (output valid, opcode, blue_in, green_in, red_in, input ready);
    modport sink (input valid, opcode, blue_in, green_in, red_in, output ready);
endinterface

interface gwwb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] blue_out;
    logic [7:0] green_out;
    logic [7:0] red_out;
    logic       last_pixel;
    modport source (output valid, blue_out, green_out, red_out, last_pixel, input ready);
    modport sink (input valid, blue_out, green_out, red_out, last_pixel, output ready);
endinterface

// File: sv/gwwb_ram.sv
module gwwb_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16384
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: sv/gwwb_div.sv
// Restoring divider, one quotient bit per cycle, rounds half to even and saturates.
module gwwb_div #(
    parameter int NUM_W = 32,
    parameter int DEN_W = 24
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [7:0]       result
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] q_reg;
    logic [DEN_W:0]   r_reg;
    logic [DEN_W-1:0] d_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DEN_W:0]   r_shift;
    logic [DEN_W+1:0] r2;
    logic             up;
    logic [NUM_W:0]   q_rnd;

    assign r_shift = {r_reg[DEN_W-1:0], q_reg[NUM_W-1]};
    assign r2 = {r_reg, 1'b0};
    assign up = (d_reg != '0) && ((r2 > {2'b00, d_reg})
              || ((r2 == {2'b00, d_reg}) && q_reg[0]));
    assign q_rnd = {1'b0, q_reg} + {{NUM_W{1'b0}}, up};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= CNT_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= num;
            r_reg <= '0;
            d_reg <= den;
        end
        else if (busy_reg)
        begin
            if (r_shift >= {1'b0, d_reg})
            begin
                r_reg <= r_shift - {1'b0, d_reg};
                q_reg <= {q_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                r_reg <= r_shift;
                q_reg <= {q_reg[NUM_W-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign result = (d_reg == '0) ? 8'd0 : (q_rnd > (NUM_W+1)'(255)) ? 8'hFF : q_rnd[7:0];
endmodule

// File: sv/gray_world_white_balance_top.sv
// Gray-world white balance.
// in: load beats (opcode 0) store a pixel and add it into the channel sums;
// once frame_pixels loads are in, the block drains. Emit beats (opcode 1)
// each return one balanced pixel; last_pixel marks the final one.
// Emit beats while loading and load beats while draining are taken and dropped.
// Load beats are taken back to back. Emit: the frame store read is registered, then three
// bit-serial dividers (one per channel, 33 steps) run in parallel, and the result is
// registered and held on out until the receiver takes it.
// One item is in flight at a time; ready is low while
// an emit is being worked on or while the result waits on a stalled receiver.
// Reset clears the sums, counters and phase; the frame store is not cleared
// and needs no clearing pass, since only written entries are read.
// frame_pixels: written by cfg_we/cfg_data, 0 acts as 1, above MAX_PIXELS saturates.
module gray_world_white_balance_top #(
    parameter int MAX_PIXELS = gwwb_pkg::MAX_PIXELS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [gwwb_pkg::CFG_W-1:0] cfg_data,
    gwwb_in_if.sink                   in,
    gwwb_out_if.source                out
);
    localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int CW = $clog2(MAX_PIXELS + 1);
    localparam int SW = CW + 8;
    localparam int NUM_W = 8 + SW + 2;
    localparam int DEN_W = SW + 2;

    gwwb_pkg::state_t state_reg, state_next;
    logic [gwwb_pkg::CFG_W-1:0] frame_reg;
    logic [SW-1:0] bsum_reg, gsum_reg, rsum_reg;
    logic [CW-1:0] load_cnt_reg, drain_idx_reg;
    logic          draining_reg;
    logic [SW+1:0] total;
    logic [CW-1:0] flen;
    logic [gwwb_pkg::CFG_W-1:0] fmask;
    logic [gwwb_pkg::PIX_W-1:0] rdata;
    logic [7:0] qb, qg, qr;
    logic [2:0] dn;
    logic [7:0] ob_reg, og_reg, or_reg;
    logic       last_reg;
    logic       ld_acc, em_acc, is_last;
    gwwb_pkg::div_ctl_t dctl;

    assign fmask = frame_reg;
    always_comb
    begin
        if (fmask == '0)
            flen = CW'(1);
        else if ({17'd0, fmask} > 32'(MAX_PIXELS))
            flen = CW'(MAX_PIXELS);
        else
            flen = CW'(fmask);
    end

    assign in.ready = (state_reg == gwwb_pkg::ST_IDLE);
    assign ld_acc = in.valid && in.ready && (in.opcode == gwwb_pkg::OP_LOAD) && !draining_reg;
    assign em_acc = in.valid && in.ready && (in.opcode == gwwb_pkg::OP_EMIT) && draining_reg;
    assign total = {2'b00, bsum_reg} + {2'b00, gsum_reg} + {2'b00, rsum_reg};
    assign is_last = (drain_idx_reg + 1'b1) >= load_cnt_reg;

    gwwb_ram #(.WIDTH(gwwb_pkg::PIX_W), .DEPTH(MAX_PIXELS)) u_store (
        .clk(clk),
        .we(ld_acc && (load_cnt_reg < CW'(MAX_PIXELS))),
        .waddr(load_cnt_reg[AW-1:0]),
        .wdata({in.red_in, in.green_in, in.blue_in}),
        .raddr(drain_idx_reg[AW-1:0]),
        .rdata(rdata)
    );

    assign dctl.start = (state_reg == gwwb_pkg::ST_READ);
    assign dctl.busy = (state_reg == gwwb_pkg::ST_DIV);
    assign dctl.done = &dn;

    gwwb_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div_b (
        .clk(clk), .rst_n(rst_n), .start(dctl.start),
        .num(NUM_W'(rdata[7:0]) * NUM_W'(total)),
        .den(DEN_W'(bsum_reg) * DEN_W'(3)), .done(dn[0]), .result(qb));
    gwwb_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div_g (
        .clk(clk), .rst_n(rst_n), .start(dctl.start),
        .num(NUM_W'(rdata[15:8]) * NUM_W'(total)),
        .den(DEN_W'(gsum_reg) * DEN_W'(3)), .done(dn[1]), .result(qg));
    gwwb_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div_r (
        .clk(clk), .rst_n(rst_n), .start(dctl.start),
        .num(NUM_W'(rdata[23:16]) * NUM_W'(total)),
        .den(DEN_W'(rsum_reg) * DEN_W'(3)), .done(dn[2]), .result(qr));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gwwb_pkg::ST_IDLE: if (em_acc) state_next = gwwb_pkg::ST_READ;
            gwwb_pkg::ST_READ: state_next = gwwb_pkg::ST_DIV;
            gwwb_pkg::ST_DIV:  if (dctl.done) state_next = gwwb_pkg::ST_OUT;
            gwwb_pkg::ST_OUT:  if (out.ready) state_next = gwwb_pkg::ST_IDLE;
            default:           state_next = gwwb_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gwwb_pkg::ST_IDLE;
            frame_reg <= gwwb_pkg::CFG_W'(gwwb_pkg::FRAME_RESET);
            bsum_reg <= '0;
            gsum_reg <= '0;
            rsum_reg <= '0;
            load_cnt_reg <= '0;
            drain_idx_reg <= '0;
            draining_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                frame_reg <= cfg_data;
            if (ld_acc)
            begin
                bsum_reg <= bsum_reg + SW'(in.blue_in);
                gsum_reg <= gsum_reg + SW'(in.green_in);
                rsum_reg <= rsum_reg + SW'(in.red_in);
                load_cnt_reg <= load_cnt_reg + 1'b1;
                if ((load_cnt_reg + 1'b1) >= flen)
                begin
                    draining_reg <= 1'b1;
                    drain_idx_reg <= '0;
                end
            end
            // the dividers latch the sums at start; clear them on the last pixel's output handoff
            if (state_reg == gwwb_pkg::ST_OUT && out.ready)
            begin
                if (last_reg)
                begin
                    bsum_reg <= '0;
                    gsum_reg <= '0;
                    rsum_reg <= '0;
                    load_cnt_reg <= '0;
                    drain_idx_reg <= '0;
                    draining_reg <= 1'b0;
                end
                else
                    drain_idx_reg <= drain_idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (dctl.busy && dctl.done)
        begin
            ob_reg <= qb;
            og_reg <= qg;
            or_reg <= qr;
            last_reg <= is_last;
        end
    end

    assign out.valid = (state_reg == gwwb_pkg::ST_OUT);
    assign out.blue_out = ob_reg;
    assign out.green_out = og_reg;
    assign out.red_out = or_reg;
    assign out.last_pixel = last_reg;
endmodule

// File: sv/gwwb_checker.sv
module gwwb_port_props (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic [7:0] blue_out
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(blue_out))
        else $error("result dropped under stall");
    a_one_flight: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input taken while result pending");
    a_after_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |=> !out_valid)
        else $error("result repeated");
endmodule

bind gray_world_white_balance_top gwwb_port_props u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in.valid), .in_ready(in.ready),
    .out_valid(out.valid), .out_ready(out.ready), .blue_out(out.blue_out));

// File: dv/gwwb_checker.sv
module gwwb_checker (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic [gwwb_pkg::CFG_W-1:0] cfg_data,
    gwwb_in_if.sink  in_mon,
    gwwb_out_if.sink out_mon,
    output int unsigned fail_count,
    output int unsigned pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDX_W = $clog2(gwwb_pkg::MAX_PIXELS_DEF);

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic       last;
    } balanced_t;

    logic [gwwb_pkg::PIX_W-1:0] pixel_mem [gwwb_pkg::MAX_PIXELS_DEF];
    logic [21:0] sum_b, sum_g, sum_r;
    int unsigned loaded, drained, frame_len_reg;
    logic drain_phase;
    balanced_t balanced_q[$];

    function automatic int unsigned active_len();
        int unsigned n;
        n = frame_len_reg;
        if (n == 0) n = 1;
        if (n > gwwb_pkg::MAX_PIXELS_DEF) n = gwwb_pkg::MAX_PIXELS_DEF;
        return n;
    endfunction

    function automatic logic [7:0] balance(logic [7:0] p, logic [23:0] total,
                                           logic [21:0] csum);
        longint unsigned num, den, q, r;
        if (csum == 0) return 8'd0;
        num = longint'(p) * total;
        den = 3 * longint'(csum);
        q = num / den;
        r = num % den;
        if (2 * r > den || (2 * r == den && q[0])) q++;
        return (q > 255) ? 8'd255 : q[7:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        balanced_t e, got;
        logic [23:0] w, total;
        if (!rst_n)
        begin
            sum_b = '0; sum_g = '0; sum_r = '0;
            loaded = 0; drained = 0; drain_phase = 0;
            frame_len_reg = gwwb_pkg::FRAME_RESET;
            fail_count = 0;
            balanced_q.delete();
            pending = 0;
        end
        else
        begin
            if (out_mon.valid && out_mon.ready)
            begin
                got = '{out_mon.blue_out, out_mon.green_out, out_mon.red_out,
                        out_mon.last_pixel};
                if (balanced_q.size() == 0)
                begin
                    $error("unexpected output beat");
                    fail_count++;
                end
                else
                begin
                    e = balanced_q.pop_front();
                    if (got.blue !== e.blue)
                    begin
                        $error("blue_out exp %0d got %0d", e.blue, got.blue); fail_count++;
                    end
                    if (got.green !== e.green)
                    begin
                        $error("green_out exp %0d got %0d", e.green, got.green); fail_count++;
                    end
                    if (got.red !== e.red)
                    begin
                        $error("red_out exp %0d got %0d", e.red, got.red); fail_count++;
                    end
                    if (got.last !== e.last)
                    begin
                        $error("last_pixel exp %0d got %0d", e.last, got.last); fail_count++;
                    end
                end
            end
            if (in_mon.valid && in_mon.ready)
            begin
                if (in_mon.opcode == gwwb_pkg::OP_LOAD)
                begin
                    if (!drain_phase)
                    begin
                        pixel_mem[IDX_W'(loaded)] =
                            {in_mon.red_in, in_mon.green_in, in_mon.blue_in};
                        sum_b += 22'(in_mon.blue_in);
                        sum_g += 22'(in_mon.green_in);
                        sum_r += 22'(in_mon.red_in);
                        loaded++;
                        if (loaded >= active_len())
                        begin
                            drain_phase = 1;
                            drained = 0;
                        end
                    end
                end
                else if (drain_phase)
                begin
                    w = pixel_mem[IDX_W'(drained)];
                    total = 24'(sum_b) + 24'(sum_g) + 24'(sum_r);
                    e.blue = balance(w[7:0], total, sum_b);
                    e.green = balance(w[15:8], total, sum_g);
                    e.red = balance(w[23:16], total, sum_r);
                    drained++;
                    e.last = (drained >= loaded);
                    if (e.last)
                    begin
                        sum_b = '0; sum_g = '0; sum_r = '0;
                        loaded = 0; drained = 0; drain_phase = 0;
                    end
                    balanced_q.push_back(e);
                end
            end
            if (cfg_we)
                frame_len_reg = 32'(cfg_data);
            pending = balanced_q.size();
        end
    end
endmodule

// File: dv/tb_gray_world_white_balance_top.sv
module tb_gray_world_white_balance_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 20000;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [gwwb_pkg::CFG_W-1:0] cfg_data;
    int unsigned fail_count, pending;
    int unsigned idle_cycles;
    logic stall_mode;

    gwwb_in_if  pix_in ();
    gwwb_out_if pix_out ();

    gray_world_white_balance_top i_dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .in(pix_in.sink), .out(pix_out.source)
    );

    gwwb_checker i_checker (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .in_mon(pix_in.sink), .out_mon(pix_out.sink),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    // receiver stall pattern: alternates between open stretches and choppy ones
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_out.ready <= 1'b0;
            stall_mode <= 1'b0;
        end
        else
        begin
            if ($urandom_range(0, 63) == 0)
                stall_mode <= ~stall_mode;
            pix_out.ready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic send_beat(logic op, logic [7:0] b, logic [7:0] g, logic [7:0] r);
        pix_in.valid <= 1'b1;
        pix_in.opcode <= op;
        pix_in.blue_in <= b;
        pix_in.green_in <= g;
        pix_in.red_in <= r;
        do @(posedge clk); while (!pix_in.ready);
    endtask

    task automatic gap();
        if ($urandom_range(0, 5) == 0)
        begin
            pix_in.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    task automatic send_rand(logic op);
        send_beat(op, 8'($urandom), 8'($urandom), 8'($urandom));
        gap();
    endtask

    // wait until the last result is out before touching the register
    task automatic write_frame_len(logic [gwwb_pkg::CFG_W-1:0] n);
        pix_in.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= n;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // one frame: loads with stray emits, then emits with stray loads
    task automatic run_frame(int unsigned n);
        for (int unsigned i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 9) == 0) send_rand(gwwb_pkg::OP_EMIT);
            send_rand(gwwb_pkg::OP_LOAD);
        end
        for (int unsigned i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 9) == 0) send_rand(gwwb_pkg::OP_LOAD);
            send_rand(gwwb_pkg::OP_EMIT);
        end
    endtask

    initial
    begin
        int unsigned items, n;
        rst_n = 0;
        cfg_we = 0;
        cfg_data = '0;
        idle_cycles = 0;
        pix_in.valid = 0;
        pix_in.opcode = gwwb_pkg::OP_LOAD;
        pix_in.blue_in = 0;
        pix_in.green_in = 0;
        pix_in.red_in = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: emit while loading, length zero, extremes, zero channel sum
        send_beat(gwwb_pkg::OP_EMIT, 8'hFF, 8'hFF, 8'hFF);
        write_frame_len(gwwb_pkg::CFG_W'(0));
        send_beat(gwwb_pkg::OP_LOAD, 8'hFF, 8'hFF, 8'hFF);
        send_beat(gwwb_pkg::OP_LOAD, 8'h12, 8'h34, 8'h56); // dropped while draining
        send_beat(gwwb_pkg::OP_EMIT, 8'd0, 8'd0, 8'd0);
        write_frame_len(gwwb_pkg::CFG_W'(3));
        send_beat(gwwb_pkg::OP_LOAD, 8'hFF, 8'h00, 8'h01);
        send_beat(gwwb_pkg::OP_LOAD, 8'h00, 8'h00, 8'hFF);
        send_beat(gwwb_pkg::OP_LOAD, 8'h01, 8'h00, 8'h80);
        repeat (3) send_beat(gwwb_pkg::OP_EMIT, 8'd0, 8'd0, 8'd0);
        write_frame_len(gwwb_pkg::CFG_W'(2));
        send_beat(gwwb_pkg::OP_LOAD, 8'hAA, 8'h55, 8'h00);
        send_beat(gwwb_pkg::OP_LOAD, 8'h55, 8'hAA, 8'h01);
        send_beat(gwwb_pkg::OP_EMIT, 8'd0, 8'd0, 8'd0);
        send_beat(gwwb_pkg::OP_EMIT, 8'd0, 8'd0, 8'd0);
        // length above the store saturates; start a frame then shrink mid-load
        write_frame_len(15'h7FFF);
        send_beat(gwwb_pkg::OP_LOAD, 8'h10, 8'h20, 8'h30);
        send_beat(gwwb_pkg::OP_LOAD, 8'h40, 8'h50, 8'h60);
        write_frame_len(gwwb_pkg::CFG_W'(1));
        send_beat(gwwb_pkg::OP_LOAD, 8'h70, 8'h80, 8'h90);
        repeat (3) send_beat(gwwb_pkg::OP_EMIT, 8'd0, 8'd0, 8'd0);

        items = 0;
        while (items < 1400)
        begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
            write_frame_len(gwwb_pkg::CFG_W'(n));
            run_frame(n);
            items += 2 * n;
        end
        pix_in.valid <= 1'b0;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

// File: filelist.f
sv/gwwb_pkg.sv
sv/gwwb_if.sv
sv/gwwb_ram.sv
sv/gwwb_div.sv
sv/gray_world_white_balance_top.sv
sv/gwwb_checker.sv
dv/gwwb_checker.sv
dv/tb_gray_world_white_balance_top.sv
